FILE: src/dtpr_pkg.sv
// ----------------------------------------------------------------------------
// dtpr_pkg
// Shared types and constants for the disparity-to-point reprojection block.
// ----------------------------------------------------------------------------
package dtpr_pkg;

    // Field and register widths.
    localparam int COEF_W         = 32;
    localparam int CFG_W          = 64;
    localparam int NUM_REGS       = 8;
    localparam int CFG_IDX_W      = 4;
    localparam int DISP_W         = 16;
    localparam int COLOR_W        = 8;
    localparam int COORD_W        = 32;
    localparam int OUT_FRAC_BITS  = 16;
    localparam int DIV_STEPS      = COORD_W;
    localparam int DEF_INDEX_BITS = 12;

    // Reset contents of the matrix registers.
    localparam logic [CFG_W-1:0] RST_Q_ROW0_LEFT  = 64'h0000_0001_0000_0000;
    localparam logic [CFG_W-1:0] RST_Q_ROW0_RIGHT = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_Q_ROW1_LEFT  = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] RST_Q_ROW1_RIGHT = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_Q_ROW2_LEFT  = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_Q_ROW2_RIGHT = 64'h0000_0001_0000_0000;
    localparam logic [CFG_W-1:0] RST_Q_ROW3_LEFT  = 64'h0000_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_Q_ROW3_RIGHT = 64'h0000_0000_0001_0000;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Q_ROW0_LEFT  = 4'd0,
        CFG_Q_ROW0_RIGHT = 4'd1,
        CFG_Q_ROW1_LEFT  = 4'd2,
        CFG_Q_ROW1_RIGHT = 4'd3,
        CFG_Q_ROW2_LEFT  = 4'd4,
        CFG_Q_ROW2_RIGHT = 4'd5,
        CFG_Q_ROW3_LEFT  = 4'd6,
        CFG_Q_ROW3_RIGHT = 4'd7
    } t_cfg_reg;

    // Pixel colour carried alongside the arithmetic.
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_color;

endpackage

FILE: src/dtpr_matmul.sv
// ----------------------------------------------------------------------------
// dtpr_matmul
// Two-stage product of the 4x4 matrix with (column, row, disparity, 1).
// ----------------------------------------------------------------------------
module dtpr_matmul #(
    parameter int INDEX_BITS = dtpr_pkg::DEF_INDEX_BITS,
    parameter int ACC_W      = 51
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [dtpr_pkg::CFG_W-1:0]          i_q [dtpr_pkg::NUM_REGS],
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [INDEX_BITS-1:0]               i_col,
    input  logic [INDEX_BITS-1:0]               i_row,
    input  logic signed [dtpr_pkg::DISP_W-1:0]  i_disp,
    input  dtpr_pkg::t_color                    i_color,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ACC_W-1:0]             o_acc [4],
    output dtpr_pkg::t_color                    o_color
);

    localparam int PC_W = dtpr_pkg::COEF_W + INDEX_BITS + 1;
    localparam int PD_W = dtpr_pkg::COEF_W + dtpr_pkg::DISP_W;
    localparam int CW   = dtpr_pkg::COEF_W;

    logic                    r_va, r_vb;
    logic                    adv_a, adv_b;
    logic signed [PC_W-1:0]  r_pc [4], n_pc [4];
    logic signed [PC_W-1:0]  r_pr [4], n_pr [4];
    logic signed [PD_W-1:0]  r_pd [4], n_pd [4];
    logic signed [CW-1:0]    r_pk [4], n_pk [4];
    logic signed [ACC_W-1:0] r_acc [4], n_acc [4];
    dtpr_pkg::t_color        r_col_a, r_col_b;

    // Each stage moves when it is empty or the next one moves.
    assign adv_b   = !r_vb || !i_stall;
    assign adv_a   = !r_va || adv_b;
    assign o_stall = !adv_a;
    assign o_valid = r_vb;
    assign o_color = r_col_b;
    assign o_acc   = r_acc;

    // First stage: the twelve coefficient products and the four constants.
    always_comb begin
        logic signed [INDEX_BITS:0] col_s;
        logic signed [INDEX_BITS:0] row_s;
        col_s = $signed({1'b0, i_col});
        row_s = $signed({1'b0, i_row});
        for (int i = 0; i < 4; i++) begin
            n_pc[i] = $signed(i_q[2*i][2*CW-1:CW]) * col_s;
            n_pr[i] = $signed(i_q[2*i][CW-1:0]) * row_s;
            n_pd[i] = $signed(i_q[2*i+1][2*CW-1:CW]) * i_disp;
            n_pk[i] = $signed(i_q[2*i+1][CW-1:0]);
        end
    end

    // Second stage: row sums, with column, row and constant scaled by 16.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_acc[i] = (ACC_W'(r_pc[i]) <<< 4) + (ACC_W'(r_pr[i]) <<< 4)
                     + ACC_W'(r_pd[i]) + (ACC_W'(r_pk[i]) <<< 4);
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (adv_a) r_va <= i_valid;
            if (adv_b) r_vb <= r_va;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_pc    <= n_pc;
            r_pr    <= n_pr;
            r_pd    <= n_pd;
            r_pk    <= n_pk;
            r_col_a <= i_color;
        end
        if (adv_b) begin
            r_acc   <= n_acc;
            r_col_b <= r_col_a;
        end
    end

endmodule

FILE: src/dtpr_divide.sv
// ----------------------------------------------------------------------------
// dtpr_divide
// Pipelined restoring division of X, Y and Z by W, one quotient bit per
// stage, with saturation to Q16.16 and the bad point flag.
// ----------------------------------------------------------------------------
module dtpr_divide #(
    parameter int ACC_W = 51
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [ACC_W-1:0]               i_acc [4],
    input  dtpr_pkg::t_color                      i_color,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [dtpr_pkg::COORD_W-1:0]   o_point [3],
    output logic                                  o_bad,
    output dtpr_pkg::t_color                      o_color
);

    localparam int STEPS = dtpr_pkg::DIV_STEPS;
    localparam int QW    = dtpr_pkg::COORD_W;
    localparam int FB    = dtpr_pkg::OUT_FRAC_BITS;
    localparam int NST   = STEPS + 2;
    localparam logic [QW-1:0] LIM_POS = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] LIM_NEG = {1'b1, {(QW-1){1'b0}}};

    logic             r_vld [NST];
    logic             adv   [NST];

    logic [ACC_W-1:0] r_rem [STEPS+1][3], n_rem [STEPS+1][3];
    logic [QW-1:0]    r_quo [STEPS+1][3], n_quo [STEPS+1][3];
    logic [QW-1:0]    r_low [STEPS+1][3], n_low [STEPS+1][3];
    logic             r_neg [STEPS+1][3], n_neg [STEPS+1][3];
    logic             r_ovf [STEPS+1][3], n_ovf [STEPS+1][3];
    logic [ACC_W-1:0] r_div [STEPS+1],    n_div [STEPS+1];
    logic             r_wz  [STEPS+1],    n_wz  [STEPS+1];
    dtpr_pkg::t_color r_col [STEPS+1];

    logic signed [QW-1:0] r_pt [3], n_pt [3];
    logic                 r_bad, n_bad;
    dtpr_pkg::t_color     r_ocol;

    // Backward stall chain: a stage loads when empty or when it drains.
    always_comb begin
        adv[NST-1] = !r_vld[NST-1] || !i_stall;
        for (int s = NST - 2; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign o_stall = !adv[0];
    assign o_valid = r_vld[NST-1];
    assign o_point = r_pt;
    assign o_bad   = r_bad;
    assign o_color = r_ocol;

    // Set-up stage and division steps.
    always_comb begin
        logic [ACC_W-1:0] un;
        logic [ACC_W-1:0] uw;
        logic [ACC_W-1:0] r2;
        logic             take;
        // Set-up: magnitudes, signs, integer-part overflow, first remainder.
        uw = i_acc[3][ACC_W-1] ? ACC_W'(-i_acc[3]) : ACC_W'(i_acc[3]);
        n_div[0] = uw;
        n_wz[0]  = (i_acc[3] == '0);
        for (int l = 0; l < 3; l++) begin
            un = i_acc[l][ACC_W-1] ? ACC_W'(-i_acc[l]) : ACC_W'(i_acc[l]);
            n_neg[0][l] = i_acc[l][ACC_W-1] ^ i_acc[3][ACC_W-1];
            n_ovf[0][l] = ({{FB{1'b0}}, un} >= {uw, {FB{1'b0}}});
            n_rem[0][l] = un >> FB;
            n_low[0][l] = {un[FB-1:0], {(QW-FB){1'b0}}};
            n_quo[0][l] = '0;
        end
        // Steps: shift in one dividend bit, trial subtract.
        r2   = '0;
        take = 1'b0;
        for (int s = 1; s <= STEPS; s++) begin
            n_div[s] = r_div[s-1];
            n_wz[s]  = r_wz[s-1];
            for (int l = 0; l < 3; l++) begin
                r2   = {r_rem[s-1][l][ACC_W-2:0], r_low[s-1][l][QW-1]};
                take = (r2 >= r_div[s-1]);
                n_rem[s][l] = take ? r2 - r_div[s-1] : r2;
                n_quo[s][l] = {r_quo[s-1][l][QW-2:0], take};
                n_low[s][l] = r_low[s-1][l] << 1;
                n_neg[s][l] = r_neg[s-1][l];
                n_ovf[s][l] = r_ovf[s-1][l];
            end
        end
    end

    // Final stage: saturate, apply sign, flag zero W and saturation.
    always_comb begin
        logic [QW-1:0] lim;
        logic [QW-1:0] mq;
        logic          sat;
        n_bad = r_wz[STEPS];
        for (int l = 0; l < 3; l++) begin
            lim = r_neg[STEPS][l] ? LIM_NEG : LIM_POS;
            sat = r_ovf[STEPS][l] || (r_quo[STEPS][l] > lim);
            mq  = sat ? lim : r_quo[STEPS][l];
            if (r_wz[STEPS]) begin
                n_pt[l] = '0;
            end else begin
                n_pt[l] = r_neg[STEPS][l] ? $signed(-mq) : $signed(mq);
                if (sat) n_bad = 1'b1;
            end
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) r_vld[s] <= 1'b0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            for (int s = 1; s < NST; s++) begin
                if (adv[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (adv[0]) r_col[0] <= i_color;
        for (int s = 0; s <= STEPS; s++) begin
            if (adv[s]) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_low[s] <= n_low[s];
                r_neg[s] <= n_neg[s];
                r_ovf[s] <= n_ovf[s];
                r_div[s] <= n_div[s];
                r_wz[s]  <= n_wz[s];
                if (s > 0) r_col[s] <= r_col[s-1];
            end
        end
        if (adv[NST-1]) begin
            r_pt   <= n_pt;
            r_bad  <= n_bad;
            r_ocol <= r_col[STEPS];
        end
    end

    // A zero W always reaches the output as a flagged point at the origin.
    a_wzero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STEPS] && r_wz[STEPS] && adv[NST-1] |=>
            o_bad && o_point[0] == '0 && o_point[1] == '0 && o_point[2] == '0)
        else $error("zero W word not flagged at the origin");

    // Reset empties the output stage.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A word held in the last division stage is not lost while it waits.
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STEPS] && !adv[STEPS] |=> r_vld[STEPS])
        else $error("stalled division word dropped");

    // An integer-part overflow of X gives the flag.
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[STEPS] && adv[NST-1] && r_ovf[STEPS][0] |=> o_bad)
        else $error("saturated X not flagged");

endmodule

FILE: src/disparity_to_point_reprojection.sv
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection
// Path from an accepted kept pixel to its word at the output:
// 2 matrix stages, 1 divider set-up stage, 32 quotient stages, 1 output stage.
// Throughput: one pixel per cycle while the output is not stalled.
// Reset empties the pipeline and loads the default matrix registers.
// ----------------------------------------------------------------------------
module disparity_to_point_reprojection #(
    parameter int INDEX_BITS = dtpr_pkg::DEF_INDEX_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [dtpr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dtpr_pkg::CFG_W-1:0]            i_cfg_data,
    // Pixel input channel.
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [INDEX_BITS-1:0]                 i_pixel_column,
    input  logic [INDEX_BITS-1:0]                 i_pixel_row,
    input  logic signed [dtpr_pkg::DISP_W-1:0]    i_disparity,
    input  logic [dtpr_pkg::COLOR_W-1:0]          i_color_blue,
    input  logic [dtpr_pkg::COLOR_W-1:0]          i_color_green,
    input  logic [dtpr_pkg::COLOR_W-1:0]          i_color_red,
    input  logic                                  i_keep_pixel,
    // Point output channel.
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [dtpr_pkg::COORD_W-1:0]   o_point_x,
    output logic signed [dtpr_pkg::COORD_W-1:0]   o_point_y,
    output logic signed [dtpr_pkg::COORD_W-1:0]   o_point_z,
    output logic [dtpr_pkg::COLOR_W-1:0]          o_out_red,
    output logic [dtpr_pkg::COLOR_W-1:0]          o_out_green,
    output logic [dtpr_pkg::COLOR_W-1:0]          o_out_blue,
    output logic                                  o_bad_point
);

    localparam int ACC_W = ((INDEX_BITS > 11) ? INDEX_BITS : 11) + 39;

    logic [dtpr_pkg::CFG_W-1:0]        r_q [dtpr_pkg::NUM_REGS];
    dtpr_pkg::t_color                  in_color;
    dtpr_pkg::t_color                  out_color;
    logic                              mm_valid;
    logic                              mm_stall;
    logic signed [ACC_W-1:0]           mm_acc [4];
    dtpr_pkg::t_color                  mm_color;
    logic signed [dtpr_pkg::COORD_W-1:0] dv_point [3];

    // Matrix registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q[0] <= dtpr_pkg::RST_Q_ROW0_LEFT;
            r_q[1] <= dtpr_pkg::RST_Q_ROW0_RIGHT;
            r_q[2] <= dtpr_pkg::RST_Q_ROW1_LEFT;
            r_q[3] <= dtpr_pkg::RST_Q_ROW1_RIGHT;
            r_q[4] <= dtpr_pkg::RST_Q_ROW2_LEFT;
            r_q[5] <= dtpr_pkg::RST_Q_ROW2_RIGHT;
            r_q[6] <= dtpr_pkg::RST_Q_ROW3_LEFT;
            r_q[7] <= dtpr_pkg::RST_Q_ROW3_RIGHT;
        end else if (i_cfg_we) begin
            case (dtpr_pkg::t_cfg_reg'(i_cfg_index))
                dtpr_pkg::CFG_Q_ROW0_LEFT:  r_q[0] <= i_cfg_data;
                dtpr_pkg::CFG_Q_ROW0_RIGHT: r_q[1] <= i_cfg_data;
                dtpr_pkg::CFG_Q_ROW1_LEFT:  r_q[2] <= i_cfg_data;
                dtpr_pkg::CFG_Q_ROW1_RIGHT: r_q[3] <= i_cfg_data;
                dtpr_pkg::CFG_Q_ROW2_LEFT:  r_q[4] <= i_cfg_data;
                dtpr_pkg::CFG_Q_ROW2_RIGHT: r_q[5] <= i_cfg_data;
                dtpr_pkg::CFG_Q_ROW3_LEFT:  r_q[6] <= i_cfg_data;
                dtpr_pkg::CFG_Q_ROW3_RIGHT: r_q[7] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Masked pixels are accepted but never enter the pipeline.
    assign in_color.red   = i_color_red;
    assign in_color.green = i_color_green;
    assign in_color.blue  = i_color_blue;

    dtpr_matmul #(
        .INDEX_BITS (INDEX_BITS),
        .ACC_W      (ACC_W)
    ) u_matmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (r_q),
        .i_valid (i_valid && i_keep_pixel),
        .o_stall (o_stall),
        .i_col   (i_pixel_column),
        .i_row   (i_pixel_row),
        .i_disp  (i_disparity),
        .i_color (in_color),
        .o_valid (mm_valid),
        .i_stall (mm_stall),
        .o_acc   (mm_acc),
        .o_color (mm_color)
    );

    dtpr_divide #(
        .ACC_W (ACC_W)
    ) u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mm_valid),
        .o_stall (mm_stall),
        .i_acc   (mm_acc),
        .i_color (mm_color),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_point (dv_point),
        .o_bad   (o_bad_point),
        .o_color (out_color)
    );

    // Output word.
    assign o_point_x   = dv_point[0];
    assign o_point_y   = dv_point[1];
    assign o_point_z   = dv_point[2];
    assign o_out_red   = out_color.red;
    assign o_out_green = out_color.green;
    assign o_out_blue  = out_color.blue;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the disparity-to-point reprojection block. Pixels
// are sent through the valid/stall input under a sequence of matrix settings,
// each point word is predicted from its pixel and the current matrix, and
// every output word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY    = 36;
    localparam int SETTLE     = LATENCY + 8;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 300;

    typedef struct {
        logic [11:0]                        column;
        logic [11:0]                        row;
        logic signed [dtpr_pkg::DISP_W-1:0] disparity;
        logic [dtpr_pkg::COLOR_W-1:0]       blue;
        logic [dtpr_pkg::COLOR_W-1:0]       green;
        logic [dtpr_pkg::COLOR_W-1:0]       red;
        logic                               keep;
    } t_pixel;

    typedef struct {
        logic signed [dtpr_pkg::COORD_W-1:0] x;
        logic signed [dtpr_pkg::COORD_W-1:0] y;
        logic signed [dtpr_pkg::COORD_W-1:0] z;
        logic [dtpr_pkg::COLOR_W-1:0]        red;
        logic [dtpr_pkg::COLOR_W-1:0]        green;
        logic [dtpr_pkg::COLOR_W-1:0]        blue;
        logic                                bad;
    } t_point;

    // Predicts point words from pixels and holds those still owed by the block.
    class point_scoreboard;
        logic [dtpr_pkg::CFG_W-1:0] q_regs[dtpr_pkg::NUM_REGS];
        t_point                     owed[$];
        int                         errors;
        int                         kept;
        int                         dropped;
        int                         matched;

        function new();
            q_regs[0] = dtpr_pkg::RST_Q_ROW0_LEFT;
            q_regs[1] = dtpr_pkg::RST_Q_ROW0_RIGHT;
            q_regs[2] = dtpr_pkg::RST_Q_ROW1_LEFT;
            q_regs[3] = dtpr_pkg::RST_Q_ROW1_RIGHT;
            q_regs[4] = dtpr_pkg::RST_Q_ROW2_LEFT;
            q_regs[5] = dtpr_pkg::RST_Q_ROW2_RIGHT;
            q_regs[6] = dtpr_pkg::RST_Q_ROW3_LEFT;
            q_regs[7] = dtpr_pkg::RST_Q_ROW3_RIGHT;
        endfunction

        function void write_reg(int idx, logic [dtpr_pkg::CFG_W-1:0] value);
            if (idx < dtpr_pkg::NUM_REGS) q_regs[idx] = value;
        endfunction

        // Signed matrix coefficient; even columns sit in the upper half.
        function longint coefficient(int r, int c);
            logic [dtpr_pkg::CFG_W-1:0] w;
            w = q_regs[r * 2 + c / 2];
            if (c % 2) return longint'($signed(w[31:0]));
            return longint'($signed(w[63:32]));
        endfunction

        // Q16.16 quotient, truncated toward zero and clamped to 32 bits.
        function logic [dtpr_pkg::COORD_W-1:0] quotient(longint n, longint d,
                                                        ref bit sat);
            longint unsigned un, ud, ip, rem, q, lim;
            bit neg;
            un  = (n < 0) ? longint'(-n) : n;
            ud  = (d < 0) ? longint'(-d) : d;
            neg = (n < 0) != (d < 0);
            ip  = un / ud;
            rem = un % ud;
            q   = ip;
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (ip >= 65536) begin
                q = lim + 1;
            end else begin
                for (int i = 0; i < dtpr_pkg::OUT_FRAC_BITS; i++) begin
                    rem = rem << 1;
                    q   = q << 1;
                    if (rem >= ud) begin
                        rem = rem - ud;
                        q   = q | 1;
                    end
                end
            end
            if (q > lim) begin
                sat = 1'b1;
                q   = lim;
            end
            if (neg) q = -q;
            return q[dtpr_pkg::COORD_W-1:0];
        endfunction

        function void note_pixel(t_pixel p);
            longint sum[4];
            bit     sat;
            t_point pt;
            if (!p.keep) begin
                dropped++;
                return;
            end
            kept++;
            for (int r = 0; r < 4; r++)
                sum[r] = coefficient(r, 0) * longint'(p.column) * 16
                       + coefficient(r, 1) * longint'(p.row) * 16
                       + coefficient(r, 2) * longint'(p.disparity)
                       + coefficient(r, 3) * 16;
            sat = 1'b0;
            if (sum[3] == 0) begin
                pt.x = '0;
                pt.y = '0;
                pt.z = '0;
                sat  = 1'b1;
            end else begin
                pt.x = quotient(sum[0], sum[3], sat);
                pt.y = quotient(sum[1], sum[3], sat);
                pt.z = quotient(sum[2], sum[3], sat);
            end
            pt.red   = p.red;
            pt.green = p.green;
            pt.blue  = p.blue;
            pt.bad   = sat;
            owed.insert(owed.size(), pt);
        endfunction

        function void check_point(t_point a);
            t_point e;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected word x=%h y=%h z=%h rgb=%h%h%h bad=%b",
                         $time, a.x, a.y, a.z, a.red, a.green, a.blue, a.bad);
                return;
            end
            e = owed.pop_front();
            if (a.x !== e.x) begin
                errors++;
                $display("%0t: x expected %h got %h", $time, e.x, a.x);
            end
            if (a.y !== e.y) begin
                errors++;
                $display("%0t: y expected %h got %h", $time, e.y, a.y);
            end
            if (a.z !== e.z) begin
                errors++;
                $display("%0t: z expected %h got %h", $time, e.z, a.z);
            end
            if (a.red !== e.red) begin
                errors++;
                $display("%0t: red expected %h got %h", $time, e.red, a.red);
            end
            if (a.green !== e.green) begin
                errors++;
                $display("%0t: green expected %h got %h", $time, e.green, a.green);
            end
            if (a.blue !== e.blue) begin
                errors++;
                $display("%0t: blue expected %h got %h", $time, e.blue, a.blue);
            end
            if (a.bad !== e.bad) begin
                errors++;
                $display("%0t: bad expected %b got %b", $time, e.bad, a.bad);
            end
            matched++;
        endfunction
    endclass

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                i_cfg_we       = 1'b0;
    logic [dtpr_pkg::CFG_IDX_W-1:0]      i_cfg_index    = '0;
    logic [dtpr_pkg::CFG_W-1:0]          i_cfg_data     = '0;
    logic                                i_valid        = 1'b0;
    logic                                o_stall;
    logic [11:0]                         i_pixel_column = '0;
    logic [11:0]                         i_pixel_row    = '0;
    logic signed [dtpr_pkg::DISP_W-1:0]  i_disparity    = '0;
    logic [dtpr_pkg::COLOR_W-1:0]        i_color_blue   = '0;
    logic [dtpr_pkg::COLOR_W-1:0]        i_color_green  = '0;
    logic [dtpr_pkg::COLOR_W-1:0]        i_color_red    = '0;
    logic                                i_keep_pixel   = 1'b0;
    logic                                o_valid;
    logic                                i_stall        = 1'b0;
    logic signed [dtpr_pkg::COORD_W-1:0] o_point_x;
    logic signed [dtpr_pkg::COORD_W-1:0] o_point_y;
    logic signed [dtpr_pkg::COORD_W-1:0] o_point_z;
    logic [dtpr_pkg::COLOR_W-1:0]        o_out_red;
    logic [dtpr_pkg::COLOR_W-1:0]        o_out_green;
    logic [dtpr_pkg::COLOR_W-1:0]        o_out_blue;
    logic                                o_bad_point;

    point_scoreboard sb = new();
    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    int hold_left = 0;
    int settings  = 0;

    disparity_to_point_reprojection u_top (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Output side: take words and apply back-pressure.
    initial begin
        t_point a;
        int     stall_left;
        int     r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                a.x     = o_point_x;
                a.y     = o_point_y;
                a.z     = o_point_z;
                a.red   = o_out_red;
                a.green = o_out_green;
                a.blue  = o_out_blue;
                a.bad   = o_bad_point;
                sb.check_point(a);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (calm) begin
                i_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    i_stall <= 1'b0;
                end else begin
                    stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                    i_stall <= 1'b1;
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves on any port.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired, %0d words outstanding",
                         $time, sb.owed.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Offer one pixel and hold it until the block takes it.
    task automatic send_pixel(t_pixel p);
        i_valid        <= 1'b1;
        i_pixel_column <= p.column;
        i_pixel_row    <= p.row;
        i_disparity    <= p.disparity;
        i_color_blue   <= p.blue;
        i_color_green  <= p.green;
        i_color_red    <= p.red;
        i_keep_pixel   <= p.keep;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(p);
    endtask

    // Random gap after a pixel: mostly none, sometimes short, rarely long.
    task automatic sender_gap();
        int r, n;
        r = $urandom_range(0, 99);
        n = 0;
        if (!calm) begin
            if (r >= 60 && r < 92) n = $urandom_range(1, 3);
            else if (r >= 92) n = $urandom_range(8, 40);
        end
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic t_pixel random_pixel();
        t_pixel p;
        int     r;
        r = $urandom_range(0, 9);
        p.column = (r == 0) ? 12'd0 : (r == 1) ? 12'hFFF : 12'($urandom);
        r = $urandom_range(0, 9);
        p.row = (r == 0) ? 12'd0 : (r == 1) ? 12'hFFF : 12'($urandom);
        r = $urandom_range(0, 9);
        p.disparity = (r == 0) ? 16'sh8000 : (r == 1) ? 16'sh7FFF : 16'($urandom);
        p.blue  = 8'($urandom);
        p.green = 8'($urandom);
        p.red   = 8'($urandom);
        p.keep  = ($urandom_range(0, 99) < 88);
        return p;
    endfunction

    // Wait until every owed word is out, then let the block settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.owed.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Load all eight matrix registers, then poke an unmapped index.
    task automatic load_matrix(logic [dtpr_pkg::CFG_W-1:0] m[dtpr_pkg::NUM_REGS]);
        dtpr_pkg::t_cfg_reg idx;
        int                 junk;
        for (int i = 0; i < dtpr_pkg::NUM_REGS; i++) begin
            idx = dtpr_pkg::t_cfg_reg'(i);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= m[i];
            @(posedge i_clk);
            sb.write_reg(i, m[i]);
        end
        junk = dtpr_pkg::NUM_REGS + $urandom_range(0, dtpr_pkg::NUM_REGS - 1);
        i_cfg_index <= dtpr_pkg::CFG_IDX_W'(junk);
        i_cfg_data  <= {$urandom, $urandom};
        @(posedge i_clk);
        sb.write_reg(junk, '0);
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    function automatic logic [dtpr_pkg::CFG_W-1:0] pair(logic [31:0] even,
                                                        logic [31:0] odd);
        return {even, odd};
    endfunction

    // Matrix for one phase of the run.
    function automatic void pick_matrix(int kind,
                                        ref logic [dtpr_pkg::CFG_W-1:0] m[dtpr_pkg::NUM_REGS]);
        logic [31:0] one, cx, cy, f, itx, off;
        one = 32'h0001_0000;
        case (kind)
            // Calibrated stereo rig with random centre, focus and baseline.
            1: begin
                cx  = -($urandom_range(0, 4095) << 16);
                cy  = -($urandom_range(0, 4095) << 16);
                f   = $urandom_range(100, 3000) << 16;
                itx = $urandom_range(1, 1 << 18);
                if ($urandom_range(0, 1)) itx = -itx;
                off = $urandom_range(0, 3) == 0 ? 32'd0 : 32'($urandom_range(0, 1 << 20));
                m = '{pair(one, 0), pair(0, cx), pair(0, one), pair(0, cy),
                      pair(0, 0), pair(0, f), pair(0, 0), pair(itx, off)};
            end
            2: foreach (m[i]) m[i] = {$urandom, $urandom};
            3: foreach (m[i])
                   m[i] = pair($urandom_range(0, 1 << 19) - (1 << 18),
                               $urandom_range(0, 1 << 19) - (1 << 18));
            4: foreach (m[i]) m[i] = pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);
            5: foreach (m[i]) m[i] = pair(32'h8000_0000, 32'h8000_0000);
            6: foreach (m[i]) m[i] = '0;
            // Almost zero W, so most coordinates clamp.
            7: m = '{dtpr_pkg::RST_Q_ROW0_LEFT, dtpr_pkg::RST_Q_ROW0_RIGHT,
                     dtpr_pkg::RST_Q_ROW1_LEFT, dtpr_pkg::RST_Q_ROW1_RIGHT,
                     dtpr_pkg::RST_Q_ROW2_LEFT, dtpr_pkg::RST_Q_ROW2_RIGHT,
                     pair(0, 0), pair(0, 1)};
            default: m = '{dtpr_pkg::RST_Q_ROW0_LEFT, dtpr_pkg::RST_Q_ROW0_RIGHT,
                           dtpr_pkg::RST_Q_ROW1_LEFT, dtpr_pkg::RST_Q_ROW1_RIGHT,
                           dtpr_pkg::RST_Q_ROW2_LEFT, dtpr_pkg::RST_Q_ROW2_RIGHT,
                           dtpr_pkg::RST_Q_ROW3_LEFT, dtpr_pkg::RST_Q_ROW3_RIGHT};
        endcase
    endfunction

    // Main sequence: directed pixels, then random phases under new matrices.
    initial begin
        logic [dtpr_pkg::CFG_W-1:0] m[dtpr_pkg::NUM_REGS];
        t_pixel                     p;
        int                         kinds[10];
        kinds = '{1, 2, 3, 4, 5, 6, 7, 1, 3, 0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pixels under the reset matrix.
        for (int k = 0; k < 20; k++) begin
            p = random_pixel();
            p.keep = 1'b1;
            case (k)
                0: p = '{12'd0, 12'd0, 16'sd0, 8'd0, 8'd0, 8'd0, 1'b1};
                1: p = '{12'hFFF, 12'hFFF, 16'sh7FFF, 8'hFF, 8'hFF, 8'hFF, 1'b1};
                2: p = '{12'hFFF, 12'd0, 16'sh8000, 8'h55, 8'hAA, 8'h0F, 1'b1};
                3: p = '{12'd0, 12'hFFF, -16'sd1, 8'hAA, 8'h55, 8'hF0, 1'b1};
                4: p.keep = 1'b0;
                5: p.disparity = 16'sd16;
                9, 14: p.keep = 1'b0;
                default: ;
            endcase
            send_pixel(p);
            sender_gap();
        end
        drain();

        // Random phases; one runs flat out and one forces a long output hold.
        foreach (kinds[ph]) begin
            pick_matrix(kinds[ph], m);
            load_matrix(m);
            calm = (ph == 2);
            if (ph == 7) hold_req = 1'b1;
            for (int k = 0; k < 93; k++) begin
                send_pixel(random_pixel());
                if (ph != 7 || k > 60) sender_gap();
            end
            drain();
        end
        calm = 1'b0;

        $display("Covered %0d matrix settings: %0d pixels kept, %0d dropped.",
                 settings + 1, sb.kept, sb.dropped);
        $display("Compared %0d point words, %0d mismatches.", sb.matched, sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
